// ===== sv/sct_pkg.sv =====
// Shared constants, codes and the CRC-8 byte update for the scratchpad temperature core.
package sct_pkg;

    localparam int NUM_PORTS   = 2;
    localparam int PORT_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int FRAME_BYTES = 9;
    localparam int CNT_W       = 4;

    localparam logic [7:0]  CRC_POLY = 8'h8C;
    localparam logic [15:0] ERR_TEMP = 16'h8000;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic ANS_CONV  = 1'b0;
    localparam logic ANS_QUERY = 1'b1;

    // reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       mix;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ b[i];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/sensor_scratchpad_crc_temperature_core.sv =====
// Top level: scratchpad CRC check, temperature conversion and per-port store.
//
// Input stream (s_axis): one transaction per scratchpad byte or query.
//   tuser selects the kind: 0 = scratchpad byte, 1 = query.
//   Nine bytes make one frame; bytes 0..7 feed the CRC, byte 8 is compared.
// Output stream (m_axis): one transaction per frame end and per query.
//   Frame end reports tenths of a degree for the current port, or -32768 on a
//   CRC mismatch; ports are served round-robin. A query returns the stored
//   value, or -32768 for an index outside the port range.
// Path: an accepted item is held in the input register, and its result is then
// registered in the output register.
// Throughput: one item per cycle unless stalled, set by the combinational CRC
// byte update and the shift-add scaling between the input and output registers.
// Stall: while m_axis_tready is low the result holds; bytes that produce no
// result keep flowing, and s_axis_tready drops only when an item that needs
// the output register waits behind an untaken result.
// Reset: CRC, byte count, raw bytes, current port and all stored temperatures
// clear to zero; both streams come up empty.
module sensor_scratchpad_crc_temperature_core
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] query_port
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] port, [16:1] temperature, [17] crc_ok
    output logic        m_axis_tuser    // [0] answer_kind
);

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [7:0]        in_data_reg;
    logic [7:0]        in_qport_reg;

    logic [7:0]        crc_reg;
    logic [CNT_W-1:0]  byte_count_reg;
    logic [7:0]        raw_low_reg;
    logic [7:0]        raw_high_reg;
    logic [PORT_W-1:0] cur_port_reg;
    logic [15:0]       port_temps_reg [NUM_PORTS];

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic              out_port_reg;
    logic [15:0]       out_temp_reg;
    logic              out_ok_reg;

    logic              frame_end;
    logic              has_result;
    logic              advance;
    logic              in_accept;

    logic signed [15:0] raw;
    logic signed [19:0] prod;
    logic signed [19:0] prod_adj;
    logic [15:0]        conv_temp;
    logic [15:0]        frame_temp;
    logic [15:0]        query_temp;
    logic               query_in_range;
    logic [7:0]         crc_next;

    logic              res_port;
    logic [15:0]       res_temp;

    assign frame_end  = (in_kind_reg == KIND_BYTE)
                        && (byte_count_reg == CNT_W'(FRAME_BYTES - 1));
    assign has_result = (in_kind_reg == KIND_QUERY) || frame_end;
    assign advance    = in_valid_reg && (!has_result || !out_valid_reg || m_axis_tready);
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !in_valid_reg || advance;

    assign crc_next = crc8_byte(crc_reg, in_data_reg);

    // raw * 10 / 16, truncating toward zero
    assign raw      = $signed({raw_high_reg, raw_low_reg});
    assign prod     = (20'(raw) <<< 3) + (20'(raw) <<< 1);
    assign prod_adj = prod + (prod[19] ? 20'sd15 : 20'sd0);
    assign conv_temp = 16'(prod_adj >>> 4);

    assign frame_temp = (crc_reg == in_data_reg) ? conv_temp : ERR_TEMP;

    assign query_in_range = (32'(in_qport_reg) < NUM_PORTS);
    assign query_temp     = query_in_range ? port_temps_reg[in_qport_reg[PORT_W-1:0]]
                                           : ERR_TEMP;

    always_comb
    begin
        if (in_kind_reg == KIND_QUERY)
        begin
            res_port = query_in_range ? in_qport_reg[0] : 1'b0;
            res_temp = query_temp;
        end
        else
        begin
            res_port = cur_port_reg[0];
            res_temp = frame_temp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg  <= s_axis_tuser;
            in_data_reg  <= s_axis_tdata[7:0];
            in_qport_reg <= s_axis_tdata[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            byte_count_reg <= '0;
            raw_low_reg    <= '0;
            raw_high_reg   <= '0;
            cur_port_reg   <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                port_temps_reg[i] <= '0;
            end
        end
        else if (advance && (in_kind_reg == KIND_BYTE))
        begin
            if (frame_end)
            begin
                port_temps_reg[cur_port_reg] <= frame_temp;
                crc_reg        <= '0;
                byte_count_reg <= '0;
                if (cur_port_reg == PORT_W'(NUM_PORTS - 1))
                begin
                    cur_port_reg <= '0;
                end
                else
                begin
                    cur_port_reg <= cur_port_reg + PORT_W'(1);
                end
            end
            else
            begin
                if (byte_count_reg == CNT_W'(0))
                begin
                    raw_low_reg <= in_data_reg;
                end
                if (byte_count_reg == CNT_W'(1))
                begin
                    raw_high_reg <= in_data_reg;
                end
                crc_reg        <= crc_next;
                byte_count_reg <= byte_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_kind_reg <= (in_kind_reg == KIND_QUERY) ? ANS_QUERY : ANS_CONV;
            out_port_reg <= res_port;
            out_temp_reg <= res_temp;
            out_ok_reg   <= (res_temp != ERR_TEMP);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'b0, out_ok_reg, out_temp_reg, out_port_reg};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(FRAME_BYTES - 1))
        else $error("byte count beyond frame length");

    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_port_reg) < NUM_PORTS)
        else $error("current port out of range");

    a_ok_matches_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ok_reg == (out_temp_reg != ERR_TEMP)))
        else $error("crc_ok disagrees with temperature");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_end) |=> (byte_count_reg == '0 && crc_reg == '0))
        else $error("frame state not cleared after last byte");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
